@@ rtl/core/e2f_pkg.sv @@
// Shared types, fixed-point constants and helpers for the equirectangular to fisheye map.
package e2f_pkg;

    localparam int unsigned NCORDIC = 24;
    localparam int unsigned XW      = 33;
    localparam int unsigned ZW      = 32;
    localparam int unsigned CFG_IW  = 4;
    localparam int unsigned CFG_DW  = 28;

    localparam logic [63:0] PI_Q28      = 64'd843314857;
    localparam logic [63:0] TWO_PI_Q28  = 64'd1686629714;
    localparam logic signed [ZW-1:0] PI_Z      = 32'sd843314857;
    localparam logic signed [ZW-1:0] TWO_PI_Z  = 32'sd1686629714;
    localparam logic signed [ZW-1:0] HALF_PI_Z = 32'sd421657428;
    localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_Q28 [NCORDIC] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
        32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
        32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
        32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32
    };

    localparam logic [CFG_IW-1:0] CFG_FOCAL_X  = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_FOCAL_Y  = 4'd1;
    localparam logic [CFG_IW-1:0] CFG_CENTRE_X = 4'd2;
    localparam logic [CFG_IW-1:0] CFG_CENTRE_Y = 4'd3;
    localparam logic [CFG_IW-1:0] CFG_DIST_K1  = 4'd4;
    localparam logic [CFG_IW-1:0] CFG_DIST_K2  = 4'd5;
    localparam logic [CFG_IW-1:0] CFG_DIST_K3  = 4'd6;
    localparam logic [CFG_IW-1:0] CFG_DIST_K4  = 4'd7;

    typedef struct packed {
        logic [9:0]  out_row;
        logic [10:0] out_col;
    } t_in;

    typedef struct packed {
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic               in_bounds;
        logic               past_limit;
    } t_out;

    // Signed shift right by n that rounds toward zero, as a C division does.
    function automatic logic signed [63:0] tdiv_p2(input logic signed [63:0] p,
                                                   input int unsigned n);
        logic signed [63:0] bias;
        bias = (p < 0) ? ((64'sd1 <<< n) - 64'sd1) : 64'sd0;
        return (p + bias) >>> n;
    endfunction

endpackage

@@ rtl/core/e2f_cordic.sv @@
// Fully unrolled rotation-mode CORDIC, one register stage per iteration.
module e2f_cordic import e2f_pkg::*; (
    input  logic                 i_clk,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_c,
    output logic signed [XW-1:0] o_s
);

    logic signed [XW-1:0] r_x [1:NCORDIC];
    logic signed [XW-1:0] r_y [1:NCORDIC];
    logic signed [ZW-1:0] r_z [1:NCORDIC];
    logic signed [XW-1:0] w_x [0:NCORDIC-1];
    logic signed [XW-1:0] w_y [0:NCORDIC-1];
    logic signed [ZW-1:0] w_z [0:NCORDIC-1];

    for (genvar g = 0; g < NCORDIC; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_x[g] = CORDIC_GAIN_Q30;
            assign w_y[g] = '0;
            assign w_z[g] = i_z;
        end else begin : g_next
            assign w_x[g] = r_x[g];
            assign w_y[g] = r_y[g];
            assign w_z[g] = r_z[g];
        end

        always_ff @(posedge i_clk) begin
            if (w_z[g] >= 0) begin
                r_x[g+1] <= w_x[g] - (w_y[g] >>> g);
                r_y[g+1] <= w_y[g] + (w_x[g] >>> g);
                r_z[g+1] <= w_z[g] - ATAN_Q28[g];
            end else begin
                r_x[g+1] <= w_x[g] + (w_y[g] >>> g);
                r_y[g+1] <= w_y[g] - (w_x[g] >>> g);
                r_z[g+1] <= w_z[g] + ATAN_Q28[g];
            end
        end
    end

    assign o_c = r_x[NCORDIC];
    assign o_s = r_y[NCORDIC];

endmodule

@@ rtl/core/equirect_to_fisheye_coord_map_core.sv @@
// Top level: pipelined equirectangular pixel to fisheye source coordinate map.
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+------------------------
//  input    | start, busy, i_in (row, column)           | start high, busy low
//  result   | o_valid, o_res (src_x, src_y, flags)      | every cycle o_valid high
//  config   | i_cfg_valid, o_cfg_ready, index, data     | valid and ready high
//
// One pixel enters every clock; busy is never raised.
// Each result passes through angle and polynomial set-up, 24 CORDIC stages, then
// scaling and saturation.
// Reset clears the valid chain and the configuration registers.
// The result side cannot stall, so the pipeline always advances.
module equirect_to_fisheye_coord_map_core import e2f_pkg::*; #(
    parameter int OUT_WIDTH  = 2048,
    parameter int OUT_HEIGHT = 1024,
    parameter int SRC_WIDTH  = 2048,
    parameter int SRC_HEIGHT = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_in,
    output logic              o_valid,
    output t_out              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int CS_END = 9 + NCORDIC;
    localparam int NSTG   = CS_END + 5;
    localparam int CMW    = $clog2(OUT_WIDTH);
    localparam int CRW    = $clog2(OUT_WIDTH) + 2;
    localparam int TRW    = $clog2(OUT_HEIGHT) + 1;

    localparam logic [63:0] W64      = 64'(OUT_WIDTH);
    localparam logic [63:0] DEN_H    = 64'(OUT_HEIGHT - 1);
    localparam logic [63:0] QT       = PI_Q28 / DEN_H;
    localparam logic [63:0] RT       = PI_Q28 % DEN_H;
    localparam logic [63:0] MT       = (64'd1 << 26) / DEN_H;
    localparam logic [63:0] MC       = (64'd1 << 26) / W64;
    localparam logic [63:0] QB       = TWO_PI_Q28 / W64;
    localparam logic [63:0] RB       = TWO_PI_Q28 % W64;
    localparam logic [63:0] PAST_LIM = 64'd95 * DEN_H;
    localparam logic signed [63:0] SRC_W64 = 64'(SRC_WIDTH);
    localparam logic signed [63:0] SRC_H64 = 64'(SRC_HEIGHT);

    // Configuration registers.
    logic        [CFG_DW-1:0] r_focal_x, r_focal_y, r_centre_x, r_centre_y;
    logic signed [CFG_DW-1:0] r_k1, r_k2, r_k3, r_k4;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= '0;
            r_focal_y  <= '0;
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_k1       <= '0;
            r_k2       <= '0;
            r_k3       <= '0;
            r_k4       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTRE_X: r_centre_x <= i_cfg_data;
                CFG_CENTRE_Y: r_centre_y <= i_cfg_data;
                CFG_DIST_K1:  r_k1       <= i_cfg_data;
                CFG_DIST_K2:  r_k2       <= i_cfg_data;
                CFG_DIST_K3:  r_k3       <= i_cfg_data;
                CFG_DIST_K4:  r_k4       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid and past-limit flags travel alongside the data.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] r_past;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-1:1], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_past <= {r_past[NSTG-1:1], (64'(i_in.out_row) * 64'd180) > PAST_LIM};
    end

    // Stage 1: reciprocal estimates for the column wrap and the polar angle.
    logic [63:0] w_colq, w_rowq, w_rowr;
    logic [10:0] r_s1_col, r_s1_colq;
    logic [29:0] r_s1_row_q;
    logic [21:0] r_s1_row_r;

    assign w_colq = 64'(i_in.out_col) * MC;
    assign w_rowq = 64'(i_in.out_row) * QT;
    assign w_rowr = 64'(i_in.out_row) * RT;

    always_ff @(posedge i_clk) begin
        r_s1_col   <= i_in.out_col;
        r_s1_colq  <= w_colq[36:26];
        r_s1_row_q <= w_rowq[29:0];
        r_s1_row_r <= w_rowr[21:0];
    end

    // Stage 2: first remainders.
    logic [63:0]    w_colr, w_thq;
    logic [CRW-1:0] r_s2_col_r;
    logic [9:0]     r_s2_th_qe;
    logic [29:0]    r_s2_row_q;
    logic [21:0]    r_s2_row_r;

    assign w_colr = 64'(r_s1_col) - 64'(r_s1_colq) * W64;
    assign w_thq  = 64'(r_s1_row_r) * MT;

    always_ff @(posedge i_clk) begin
        r_s2_col_r <= w_colr[CRW-1:0];
        r_s2_th_qe <= w_thq[35:26];
        r_s2_row_q <= r_s1_row_q;
        r_s2_row_r <= r_s1_row_r;
    end

    // Stage 3: column corrected into range; polar remainder formed.
    logic [63:0]    w_colm, w_thrr;
    logic [CMW-1:0] r_s3_col_m;
    logic [TRW-1:0] r_s3_th_rr;
    logic [9:0]     r_s3_th_qe;
    logic [29:0]    r_s3_row_q;

    assign w_colm = (64'(r_s2_col_r) >= W64) ? (64'(r_s2_col_r) - W64) : 64'(r_s2_col_r);
    assign w_thrr = 64'(r_s2_row_r) - 64'(r_s2_th_qe) * DEN_H;

    always_ff @(posedge i_clk) begin
        r_s3_col_m <= w_colm[CMW-1:0];
        r_s3_th_rr <= w_thrr[TRW-1:0];
        r_s3_th_qe <= r_s2_th_qe;
        r_s3_row_q <= r_s2_row_q;
    end

    // Stage 4: polar angle complete; azimuth split into whole and fractional parts.
    logic [63:0] w_theta, w_bx, w_bb;
    logic [29:0] r_s4_theta;
    logic [25:0] r_s4_bx;
    logic [30:0] r_s4_bb;

    assign w_theta = 64'(r_s3_row_q) + 64'(r_s3_th_qe)
                   + ((64'(r_s3_th_rr) >= DEN_H) ? 64'd1 : 64'd0);
    assign w_bx = 64'(r_s3_col_m) * RB;
    assign w_bb = 64'(r_s3_col_m) * QB;

    always_ff @(posedge i_clk) begin
        r_s4_theta <= w_theta[29:0];
        r_s4_bx    <= w_bx[25:0];
        r_s4_bb    <= w_bb[30:0];
    end

    // Stage 5: theta squared; azimuth quotient estimate.
    logic [63:0]    w_t2, w_bq;
    logic [25:0]    r_s5_t2, r_s5_t24, r_s5_bx;
    logic [CMW-1:0] r_s5_bqe;
    logic [30:0]    r_s5_bb;

    assign w_t2 = 64'(r_s4_theta) * 64'(r_s4_theta);
    assign w_bq = 64'(r_s4_bx) * MC;

    always_ff @(posedge i_clk) begin
        r_s5_t2  <= w_t2[57:32];
        r_s5_t24 <= r_s4_theta[29:4];
        r_s5_bqe <= w_bq[CMW+25:26];
        r_s5_bx  <= r_s4_bx;
        r_s5_bb  <= r_s4_bb;
    end

    // Stages 6 to 9: Horner steps of the distortion polynomial, one per stage.
    logic signed [63:0] w_t2s5, w_t2s6, w_t2s7, w_t2s8;
    logic signed [63:0] w_h6, w_h7, w_h8, w_h9;
    logic [63:0]        w_br;
    logic signed [35:0] r_s6_acc, r_s7_acc, r_s8_acc, r_s9_acc;
    logic [25:0]        r_s6_t2, r_s7_t2, r_s8_t2;
    logic [25:0]        r_s6_t24, r_s7_t24, r_s8_t24, r_s9_t24;
    logic [CRW-1:0]     r_s6_br;
    logic [CMW-1:0]     r_s6_bqe;
    logic [30:0]        r_s6_bb;

    assign w_t2s5 = signed'({38'd0, r_s5_t2});
    assign w_t2s6 = signed'({38'd0, r_s6_t2});
    assign w_t2s7 = signed'({38'd0, r_s7_t2});
    assign w_t2s8 = signed'({38'd0, r_s8_t2});
    assign w_h6 = tdiv_p2(64'(r_k4) * w_t2s5, 24) + 64'(r_k3);
    assign w_h7 = tdiv_p2(64'(r_s6_acc) * w_t2s6, 24) + 64'(r_k2);
    assign w_h8 = tdiv_p2(64'(r_s7_acc) * w_t2s7, 24) + 64'(r_k1);
    assign w_h9 = tdiv_p2(64'(r_s8_acc) * w_t2s8, 24) + ONE_Q24;
    assign w_br = 64'(r_s5_bx) - 64'(r_s5_bqe) * W64;

    // Azimuth: final quotient correction, wrap to (-pi, pi], fold into +-pi/2.
    logic [63:0]          w_beta;
    logic [30:0]          r_s7_beta;
    logic signed [ZW-1:0] w_z7s, w_z8, w_z9;
    logic signed [ZW-1:0] r_s8_z, r_s9_z;
    logic                 w_neg9;
    logic [CS_END:9]      r_neg;

    assign w_beta = 64'(r_s6_bb) + 64'(r_s6_bqe)
                  + ((64'(r_s6_br) >= W64) ? 64'd1 : 64'd0);
    assign w_z7s  = signed'({1'b0, r_s7_beta});
    assign w_z8   = (w_z7s > PI_Z) ? (w_z7s - TWO_PI_Z) : w_z7s;

    always_comb begin
        w_z9   = r_s8_z;
        w_neg9 = 1'b0;
        if (r_s8_z > HALF_PI_Z) begin
            w_z9   = r_s8_z - PI_Z;
            w_neg9 = 1'b1;
        end else if (r_s8_z < -HALF_PI_Z) begin
            w_z9   = r_s8_z + PI_Z;
            w_neg9 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_acc  <= w_h6[35:0];
        r_s7_acc  <= w_h7[35:0];
        r_s8_acc  <= w_h8[35:0];
        r_s9_acc  <= w_h9[35:0];
        r_s6_t2   <= r_s5_t2;
        r_s7_t2   <= r_s6_t2;
        r_s8_t2   <= r_s7_t2;
        r_s6_t24  <= r_s5_t24;
        r_s7_t24  <= r_s6_t24;
        r_s8_t24  <= r_s7_t24;
        r_s9_t24  <= r_s8_t24;
        r_s6_br   <= w_br[CRW-1:0];
        r_s6_bqe  <= r_s5_bqe;
        r_s6_bb   <= r_s5_bb;
        r_s7_beta <= w_beta[30:0];
        r_s8_z    <= w_z8;
        r_s9_z    <= w_z9;
        r_neg     <= {r_neg[CS_END-1:9], w_neg9};
    end

    // Distorted angle, held back to meet the CORDIC output.
    logic signed [63:0] w_td;
    logic signed [36:0] r_td [10:CS_END+1];

    assign w_td = tdiv_p2(64'(r_s9_acc) * signed'({38'd0, r_s9_t24}), 24);

    always_ff @(posedge i_clk) begin
        r_td[10] <= w_td[36:0];
        for (int k = 11; k <= CS_END + 1; k++) begin
            r_td[k] <= r_td[k-1];
        end
    end

    logic signed [XW-1:0] w_cos, w_sin;

    e2f_cordic u_cordic (
        .i_clk (i_clk),
        .i_z   (r_s9_z),
        .o_c   (w_cos),
        .o_s   (w_sin)
    );

    // Sign restore and scaling to Q.24, then camera matrix and pixel conversion.
    logic signed [63:0] w_cq, w_sq, w_u, w_v, w_xf, w_yf, w_px, w_py;
    logic signed [25:0] r_c, r_s;
    logic signed [28:0] r_u, r_v;
    logic signed [43:0] r_xf, r_yf;
    logic signed [27:0] r_px, r_py;

    assign w_cq = tdiv_p2(r_neg[CS_END] ? -64'(w_cos) : 64'(w_cos), 6);
    assign w_sq = tdiv_p2(r_neg[CS_END] ? -64'(w_sin) : 64'(w_sin), 6);
    assign w_u  = tdiv_p2(64'(r_td[CS_END+1]) * 64'(r_c), 32);
    assign w_v  = tdiv_p2(64'(r_td[CS_END+1]) * 64'(r_s), 32);
    assign w_xf = tdiv_p2(signed'({36'd0, r_focal_x}) * 64'(r_u), 16)
                + signed'({36'd0, r_centre_x});
    assign w_yf = tdiv_p2(signed'({36'd0, r_focal_y}) * 64'(r_v), 16)
                + signed'({36'd0, r_centre_y});
    assign w_px = tdiv_p2(64'(r_xf), 16);
    assign w_py = tdiv_p2(64'(r_yf), 16);

    always_ff @(posedge i_clk) begin
        r_c  <= w_cq[25:0];
        r_s  <= w_sq[25:0];
        r_u  <= w_u[28:0];
        r_v  <= w_v[28:0];
        r_xf <= w_xf[43:0];
        r_yf <= w_yf[43:0];
        r_px <= w_px[27:0];
        r_py <= w_py[27:0];
    end

    // Final stage: bounds test before saturation, past-limit rows forced to zero.
    t_out               r_res;
    t_out               w_res;
    logic signed [63:0] w_px64, w_py64;

    assign w_px64 = 64'(r_px);
    assign w_py64 = 64'(r_py);

    always_comb begin
        w_res = '0;
        if (r_past[NSTG-1]) begin
            w_res.past_limit = 1'b1;
        end else begin
            if (w_px64 > 64'sd32767) begin
                w_res.src_x = 16'sh7fff;
            end else if (w_px64 < -64'sd32768) begin
                w_res.src_x = 16'sh8000;
            end else begin
                w_res.src_x = r_px[15:0];
            end
            if (w_py64 > 64'sd32767) begin
                w_res.src_y = 16'sh7fff;
            end else if (w_py64 < -64'sd32768) begin
                w_res.src_y = 16'sh8000;
            end else begin
                w_res.src_y = r_py[15:0];
            end
            w_res.in_bounds = (w_px64 >= 0) && (w_px64 < SRC_W64)
                           && (w_py64 >= 0) && (w_py64 < SRC_H64);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= w_res;
    end

    assign o_res   = r_res;
    assign o_valid = r_vld[NSTG];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##NSTG o_valid)
        else $error("transfer did not produce a result on time");
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, NSTG))
        else $error("result without a matching transfer");
    a_past_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.past_limit) |->
            (!o_res.in_bounds && o_res.src_x == 16'sd0 && o_res.src_y == 16'sd0))
        else $error("past-limit result carries coordinates");
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.in_bounds) |->
            (o_res.src_x >= 0 && 64'(o_res.src_x) < SRC_W64
             && o_res.src_y >= 0 && 64'(o_res.src_y) < SRC_H64))
        else $error("in-bounds flag disagrees with coordinates");
`endif

endmodule

@@ tb/sv/tb_equirect_to_fisheye_coord_map_core.sv @@
// Self-checking testbench for the equirectangular to fisheye coordinate map core.
module tb_equirect_to_fisheye_coord_map_core;
    import e2f_pkg::*;

    localparam int OUT_W = 2048;
    localparam int OUT_H = 1024;
    localparam int SRC_W = 2048;
    localparam int SRC_H = 2048;
    localparam int PIPE_DEPTH = 38;
    localparam int STALL_LIMIT = 4000;
    localparam logic signed [63:0] PI_FX = 64'sd843314857;
    localparam logic signed [63:0] GAIN_FX = 64'sd652032874;
    localparam logic signed [63:0] UNIT_Q24 = 64'sd16777216;

    localparam logic signed [63:0] ARCTAN [24] = '{
        64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290, 64'sd16755422,
        64'sd8385879, 64'sd4193963, 64'sd2097109, 64'sd1048571, 64'sd524287,
        64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
        64'sd4096, 64'sd2048, 64'sd1024, 64'sd512, 64'sd256, 64'sd128, 64'sd64, 64'sd32
    };

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in i_in;
    logic o_valid;
    t_out o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    // Mid-cycle copies of the handshakes, so that nothing depends on event order at the edge.
    logic pix_take;
    logic cfg_take;
    logic res_seen;

    logic signed [63:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic signed [63:0] k_reg [4];

    t_out expected_coords [$];
    int unsigned quiet_cycles;
    bit failed;
    bit idle_on;

    equirect_to_fisheye_coord_map_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [15:0] clamp16(logic signed [63:0] v);
        if (v > 64'sd32767) return 16'sh7fff;
        if (v < -64'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_out map_pixel(t_in px);
        logic signed [63:0] row, col, theta, t2, t24, acc, thetad, beta;
        logic signed [63:0] cx, sy, nx, z, u, v, xx, yy, sx, sy_px;
        logic [63:0] sq;
        bit flip;
        t_out r;
        row = 64'(px.out_row);
        col = 64'(px.out_col) % OUT_W;
        flip = 1'b0;
        r = '0;
        if (row * 180 > 95 * (OUT_H - 1)) begin
            r.past_limit = 1'b1;
            return r;
        end
        theta = (row * PI_FX) / (OUT_H - 1);
        sq = theta * theta;
        t2 = sq >> 32;
        t24 = theta / 16;
        acc = k_reg[3];
        acc = (acc * t2) / UNIT_Q24 + k_reg[2];
        acc = (acc * t2) / UNIT_Q24 + k_reg[1];
        acc = (acc * t2) / UNIT_Q24 + k_reg[0];
        acc = (acc * t2) / UNIT_Q24 + UNIT_Q24;
        thetad = (acc * t24) / UNIT_Q24;
        beta = (col * 2 * PI_FX) / OUT_W;
        if (beta > PI_FX) beta = beta - 2 * PI_FX;
        if (beta > PI_FX / 2) begin
            beta = beta - PI_FX;
            flip = 1'b1;
        end else if (beta < -(PI_FX / 2)) begin
            beta = beta + PI_FX;
            flip = 1'b1;
        end
        cx = GAIN_FX;
        sy = 0;
        z = beta;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = cx - floor_shift(sy, i);
                sy = sy + floor_shift(cx, i);
                z = z - ARCTAN[i];
            end else begin
                nx = cx + floor_shift(sy, i);
                sy = sy - floor_shift(cx, i);
                z = z + ARCTAN[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        cx = cx / 64;
        sy = sy / 64;
        u = (thetad * cx) / 64'sd4294967296;
        v = (thetad * sy) / 64'sd4294967296;
        xx = (fx_reg * u) / 65536 + cx_reg;
        yy = (fy_reg * v) / 65536 + cy_reg;
        sx = xx / 65536;
        sy_px = yy / 65536;
        r.src_x = clamp16(sx);
        r.src_y = clamp16(sy_px);
        r.in_bounds = sx >= 0 && sx < SRC_W && sy_px >= 0 && sy_px < SRC_H;
        return r;
    endfunction

    always @(negedge i_clk) begin
        pix_take <= start && !busy;
        cfg_take <= i_cfg_valid && o_cfg_ready;
        res_seen <= o_valid;
        if (i_rst_n && o_valid) begin
            if (expected_coords.size() == 0) begin
                $error("result with nothing expected: %p", o_res);
                failed = 1'b1;
            end else begin
                t_out e;
                e = expected_coords.pop_front();
                if (o_res.src_x !== e.src_x) begin
                    $error("src_x expected %0d actual %0d", e.src_x, o_res.src_x);
                    failed = 1'b1;
                end
                if (o_res.src_y !== e.src_y) begin
                    $error("src_y expected %0d actual %0d", e.src_y, o_res.src_y);
                    failed = 1'b1;
                end
                if (o_res.in_bounds !== e.in_bounds) begin
                    $error("in_bounds expected %0b actual %0b", e.in_bounds, o_res.in_bounds);
                    failed = 1'b1;
                end
                if (o_res.past_limit !== e.past_limit) begin
                    $error("past_limit expected %0b actual %0b",
                           e.past_limit, o_res.past_limit);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (pix_take || cfg_take || res_seen || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic idle_gap();
        while (idle_on && $urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Start stays high after a transfer; the next call or the drain decides its level.
    task automatic send_pixel(t_in px, bit typed, t_out typed_res);
        idle_gap();
        i_cfg_valid <= 1'b0;
        start <= 1'b1;
        i_in <= px;
        @(posedge i_clk);
        while (!pix_take) @(posedge i_clk);
        expected_coords.insert(expected_coords.size(), typed ? typed_res : map_pixel(px));
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        logic signed [63:0] sv;
        idle_gap();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_take) @(posedge i_clk);
        sv = $signed({{36{data[CFG_DW-1]}}, data});
        case (idx)
            CFG_FOCAL_X:  fx_reg = data;
            CFG_FOCAL_Y:  fy_reg = data;
            CFG_CENTRE_X: cx_reg = data;
            CFG_CENTRE_Y: cy_reg = data;
            CFG_DIST_K1:  k_reg[0] = sv;
            CFG_DIST_K2:  k_reg[1] = sv;
            CFG_DIST_K3:  k_reg[2] = sv;
            CFG_DIST_K4:  k_reg[3] = sv;
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_coords.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DW-1:0] small_k();
        return CFG_DW'($signed($urandom_range(0, 3200000)) - 1600000);
    endfunction

    typedef struct {
        int row;
        int col;
        bit typed;
        t_out res;
    } t_row;

    localparam t_out AT_ORIGIN = '{src_x: 16'sd0, src_y: 16'sd0, in_bounds: 1'b1,
                                   past_limit: 1'b0};
    localparam t_out PAST = '{src_x: 16'sd0, src_y: 16'sd0, in_bounds: 1'b0,
                              past_limit: 1'b1};

    // With every register at zero each row inside the limit maps to the origin.
    t_row directed [] = '{
        '{0, 0, 1, AT_ORIGIN}, '{0, 2047, 1, AT_ORIGIN}, '{539, 0, 1, AT_ORIGIN},
        '{539, 2047, 1, AT_ORIGIN}, '{540, 0, 1, PAST}, '{540, 1024, 1, PAST},
        '{1023, 0, 1, PAST}, '{1023, 2047, 1, PAST}, '{1000, 1365, 1, PAST},
        '{256, 512, 1, AT_ORIGIN}, '{256, 1536, 1, AT_ORIGIN}, '{511, 1024, 1, AT_ORIGIN},
        '{1, 1, 0, AT_ORIGIN}, '{682, 682, 0, PAST}, '{341, 1023, 0, AT_ORIGIN},
        '{100, 1025, 0, AT_ORIGIN}
    };

    initial begin
        t_in px;
        logic [CFG_DW-1:0] regs [8];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        failed = 1'b0;
        idle_on = 1'b1;
        fx_reg = 0; fy_reg = 0; cx_reg = 0; cy_reg = 0;
        for (int i = 0; i < 4; i++) k_reg[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            px.out_row = 10'(directed[i].row);
            px.out_col = 11'(directed[i].col);
            send_pixel(px, directed[i].typed, directed[i].res);
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            for (int r = 0; r < 8; r++) begin
                case (ph)
                    1: regs[r] = (r < 4) ? 28'hfffffff : 28'h7ffffff;
                    2: regs[r] = (r < 4) ? 28'h0 : 28'h8000000;
                    3: regs[r] = CFG_DW'($urandom);
                    default: begin
                        if (r < 2) regs[r] = CFG_DW'($urandom_range(200 << 16, 1200 << 16));
                        else if (r < 4)
                            regs[r] = CFG_DW'($urandom_range(0, (ph == 5) ? 4000 << 16
                                                                         : 2047 << 16));
                        else regs[r] = small_k();
                    end
                endcase
            end
            for (int r = 0; r < 8; r++) write_reg(r[CFG_IW-1:0], regs[r]);
            // Indices past the register list are ignored by the block.
            write_reg(CFG_DIST_K4 + 4'd1 + 4'($urandom_range(0, 7)), CFG_DW'($urandom));
            idle_on = (ph != 4);
            for (int n = 0; n < 142; n++) begin
                px.out_col = 11'($urandom_range(0, 2047));
                px.out_row = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 539))
                                                         : 10'($urandom_range(0, 1023));
                send_pixel(px, 1'b0, AT_ORIGIN);
            end
            idle_on = 1'b1;
        end

        drain();
        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
